FILE: design/lba_pkg.sv
// Shared types and constants for the linked block allocator.
// Used by lba_ctrl, lba_datapath and linked_block_allocator; no dependencies.
package lba_pkg;

    localparam int NUM_BLOCKS = 128;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int IDX1_W     = IDX_W + 1;
    localparam int NAME_W     = 16;
    localparam int WANT_W     = 8;
    localparam int START_W    = 7;
    localparam int RUN_W      = (IDX1_W > WANT_W) ? IDX1_W : WANT_W;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_TAKEN    = 3'd2,
        ST_NOSPACE  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_ZERO     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_NSCAN,
        S_FSCAN,
        S_RUN,
        S_CLAIM,
        S_DREAD,
        S_DFREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    scan_start;
        logic    scan_step;
        logic    take_hit;
        logic    idx_inc;
        logic    run_start;
        logic    run_inc;
        logic    claim_start;
        logic    claim_step;
        logic    link_read;
        logic    free_step;
        logic    push;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic name_empty;
        logic is_delete;
        logic want_zero;
        logic scan_hit;
        logic scan_last;
        logic at_end;
        logic cur_used;
        logic run_ge_want;
        logic claim_last;
        logic link_self;
        logic out_free;
    } t_sts;

endpackage

FILE: design/linked_block_allocator.sv
// Linked block allocator: a table of NUM_BLOCKS blocks handed out to named files
// as contiguous chains. Top level; depends on lba_pkg, lba_ctrl, lba_datapath.
//
// Request channel (i_valid/o_ready): one beat carries i_action (0 add, 1 delete),
// i_file_name and i_block_count. Result channel (o_valid/i_ready): one beat per
// request with o_status and o_start_block (zero unless status is ok).
// A request is taken only when the sequencer is idle. Each request with a
// non-empty name first scans the owner table, one block a cycle through a
// registered RAM read. An add then searches the used marks for the first free
// block and its free run (one block a cycle) and claims one block a cycle. A
// delete walks the chain, reading each block's link and then freeing the block.
// The result sits in an output register; the next request is accepted while it
// waits. If the receiver stalls, the following request finishes its work and
// holds until the result register is free.
// Reset clears every used mark at once; the block is ready in the next cycle.
module linked_block_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  logic [lba_pkg::NAME_W-1:0]  i_file_name,
    input  logic [lba_pkg::WANT_W-1:0]  i_block_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_status,
    output logic [lba_pkg::START_W-1:0] o_start_block
);

    lba_pkg::t_cmd cmd;
    lba_pkg::t_sts sts;

    lba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lba_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_action),
        .i_file_name   (i_file_name),
        .i_block_count (i_block_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_start_block (o_start_block)
    );

endmodule

FILE: design/lba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/lba_ctrl.sv
// Request sequencer for the linked block allocator.
// Depends on lba_pkg; drives lba_datapath through t_cmd and reads t_sts.
module lba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lba_pkg::t_sts i_sts,
    output lba_pkg::t_cmd o_cmd
);

    lba_pkg::t_state  r_state, n_state;
    lba_pkg::t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lba_pkg::S_IDLE;
            r_code  <= lba_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_cmd      = '0;
        o_cmd.code = r_code;
        o_ready    = 1'b0;
        case (r_state)
            lba_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lba_pkg::S_CHECK;
                end
            end
            lba_pkg::S_CHECK: begin
                if (i_sts.name_empty) begin
                    n_code  = lba_pkg::ST_EMPTY;
                    n_state = lba_pkg::S_DONE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = lba_pkg::S_NSCAN;
                end
            end
            lba_pkg::S_NSCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_hit) begin
                    if (i_sts.is_delete) begin
                        o_cmd.take_hit = 1'b1;
                        n_state        = lba_pkg::S_DREAD;
                    end else begin
                        n_code  = lba_pkg::ST_TAKEN;
                        n_state = lba_pkg::S_DONE;
                    end
                end else if (i_sts.scan_last) begin
                    if (i_sts.is_delete) begin
                        n_code  = lba_pkg::ST_NOTFOUND;
                        n_state = lba_pkg::S_DONE;
                    end else if (i_sts.want_zero) begin
                        n_code  = lba_pkg::ST_ZERO;
                        n_state = lba_pkg::S_DONE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = lba_pkg::S_FSCAN;
                    end
                end
            end
            lba_pkg::S_FSCAN: begin
                if (i_sts.at_end) begin
                    n_code  = lba_pkg::ST_NOSPACE;
                    n_state = lba_pkg::S_DONE;
                end else if (i_sts.cur_used) begin
                    o_cmd.idx_inc = 1'b1;
                end else begin
                    o_cmd.run_start = 1'b1;
                    n_state         = lba_pkg::S_RUN;
                end
            end
            lba_pkg::S_RUN: begin
                if (!i_sts.at_end && !i_sts.cur_used && !i_sts.run_ge_want) begin
                    o_cmd.run_inc = 1'b1;
                end else if (i_sts.run_ge_want) begin
                    o_cmd.claim_start = 1'b1;
                    n_state           = lba_pkg::S_CLAIM;
                end else begin
                    n_code  = lba_pkg::ST_NOSPACE;
                    n_state = lba_pkg::S_DONE;
                end
            end
            lba_pkg::S_CLAIM: begin
                o_cmd.claim_step = 1'b1;
                if (i_sts.claim_last) begin
                    n_code  = lba_pkg::ST_OK;
                    n_state = lba_pkg::S_DONE;
                end
            end
            lba_pkg::S_DREAD: begin
                o_cmd.link_read = 1'b1;
                n_state         = lba_pkg::S_DFREE;
            end
            lba_pkg::S_DFREE: begin
                o_cmd.free_step = 1'b1;
                if (i_sts.link_self) begin
                    n_code  = lba_pkg::ST_OK;
                    n_state = lba_pkg::S_DONE;
                end else begin
                    n_state = lba_pkg::S_DREAD;
                end
            end
            lba_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = lba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/lba_datapath.sv
// Block table, scan counters and result register of the allocator.
// Depends on lba_pkg and lba_ram; controlled by lba_ctrl through t_cmd.
module lba_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lba_pkg::t_cmd                 i_cmd,
    output lba_pkg::t_sts                 o_sts,
    input  logic                          i_action,
    input  logic [lba_pkg::NAME_W-1:0]    i_file_name,
    input  logic [lba_pkg::WANT_W-1:0]    i_block_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_status,
    output logic [lba_pkg::START_W-1:0]   o_start_block
);

    logic                        r_used [lba_pkg::NUM_BLOCKS];
    logic                        r_action;
    logic [lba_pkg::NAME_W-1:0]  r_name;
    logic [lba_pkg::WANT_W-1:0]  r_want;
    logic [lba_pkg::IDX1_W-1:0]  r_idx;
    logic                        r_rd_vld;
    logic [lba_pkg::IDX_W-1:0]   r_rd_idx;
    logic [lba_pkg::IDX_W-1:0]   r_pos;
    logic [lba_pkg::RUN_W-1:0]   r_run;
    logic [lba_pkg::IDX_W-1:0]   r_cur;
    logic [lba_pkg::IDX_W-1:0]   r_start;
    logic                        r_out_valid;
    lba_pkg::t_status            r_out_status;
    logic [lba_pkg::START_W-1:0] r_out_start;

    logic [lba_pkg::NAME_W-1:0]          owner_rd;
    logic [lba_pkg::IDX_W-1:0]           link_rd;
    logic [lba_pkg::IDX_W-1:0]           idx_lo;
    logic [lba_pkg::IDX_W-1:0]           link_wdata;
    logic                                in_table;
    logic                                scan_re;
    logic [lba_pkg::RUN_W-1:0]           want_ext;
    logic [lba_pkg::IDX_W+lba_pkg::START_W-1:0] start_ext;

    assign idx_lo    = r_idx[lba_pkg::IDX_W-1:0];
    assign in_table  = (r_idx < lba_pkg::IDX1_W'(lba_pkg::NUM_BLOCKS));
    assign scan_re   = i_cmd.scan_step && in_table;
    assign want_ext  = lba_pkg::RUN_W'(r_want);
    assign start_ext = (lba_pkg::IDX_W + lba_pkg::START_W)'(r_start);
    // last block of the chain links to itself
    assign link_wdata = o_sts.claim_last ? idx_lo : idx_lo + 1'b1;

    lba_ram #(
        .WIDTH (lba_pkg::NAME_W),
        .DEPTH (lba_pkg::NUM_BLOCKS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.claim_step),
        .i_waddr (idx_lo),
        .i_wdata (r_name),
        .i_re    (scan_re),
        .i_raddr (idx_lo),
        .o_rdata (owner_rd)
    );

    lba_ram #(
        .WIDTH (lba_pkg::IDX_W),
        .DEPTH (lba_pkg::NUM_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.claim_step),
        .i_waddr (idx_lo),
        .i_wdata (link_wdata),
        .i_re    (i_cmd.link_read),
        .i_raddr (r_cur),
        .o_rdata (link_rd)
    );

    always_comb begin
        o_sts.name_empty  = (r_name[lba_pkg::NAME_W-1:8] == '0);
        o_sts.is_delete   = r_action;
        o_sts.want_zero   = (r_want == '0);
        o_sts.scan_hit    = r_rd_vld && r_used[r_rd_idx] && (owner_rd == r_name);
        o_sts.scan_last   = r_rd_vld && (r_rd_idx == lba_pkg::IDX_W'(lba_pkg::NUM_BLOCKS - 1));
        o_sts.at_end      = !in_table;
        o_sts.cur_used    = r_used[idx_lo];
        o_sts.run_ge_want = (r_run >= want_ext);
        o_sts.claim_last  = (r_run == lba_pkg::RUN_W'(1));
        o_sts.link_self   = (link_rd == r_cur);
        o_sts.out_free    = !r_out_valid || i_ready;
    end

    // used marks: cleared at reset, set on claim, dropped along a deleted chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lba_pkg::NUM_BLOCKS; i++) begin
                r_used[i] <= 1'b0;
            end
        end else if (i_cmd.claim_step) begin
            r_used[idx_lo] <= 1'b1;
        end else if (i_cmd.free_step) begin
            r_used[r_cur] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= in_table;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_name   <= i_file_name;
            r_want   <= i_block_count;
        end
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (scan_re || i_cmd.idx_inc || i_cmd.run_inc || i_cmd.claim_step) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.claim_start) begin
            r_idx <= lba_pkg::IDX1_W'(r_pos);
        end
        if (i_cmd.scan_step) begin
            r_rd_idx <= idx_lo;
        end
        if (i_cmd.run_start) begin
            r_pos <= idx_lo;
            r_run <= '0;
        end else if (i_cmd.run_inc) begin
            r_run <= r_run + 1'b1;
        end else if (i_cmd.claim_step) begin
            r_run <= r_run - 1'b1;
        end
        if (i_cmd.take_hit) begin
            r_cur   <= r_rd_idx;
            r_start <= r_rd_idx;
        end else if (i_cmd.free_step) begin
            r_cur <= link_rd;
        end else if (i_cmd.claim_start) begin
            r_start <= r_pos;
        end
        if (i_cmd.push) begin
            r_out_status <= i_cmd.code;
            r_out_start  <= (i_cmd.code == lba_pkg::ST_OK) ?
                            start_ext[lba_pkg::START_W-1:0] : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_start_block = r_out_start;

    a_claim_free_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim_step |-> (in_table && !r_used[idx_lo]))
        else $error("claim hits a block already in use");

    a_free_used_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.free_step |-> r_used[r_cur])
        else $error("chain walk frees a block that is not in use");

    a_push_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!r_out_valid || i_ready))
        else $error("result pushed over a result still waiting");

    a_claim_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim_step |=> r_used[$past(idx_lo)])
        else $error("claimed block not marked used");

endmodule

FILE: verif/lba_checker.sv
`timescale 1ns / 1ps
// Scoreboard for linked_block_allocator: keeps its own block table, predicts the
// reply to every request beat and compares it with every reply beat. Depends on lba_pkg.
module lba_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic                        i_action,
    input  logic [lba_pkg::NAME_W-1:0]  i_file_name,
    input  logic [lba_pkg::WANT_W-1:0]  i_block_count,
    input  logic                        i_rsp_valid,
    input  logic                        i_rsp_ready,
    input  logic [2:0]                  i_status,
    input  logic [lba_pkg::START_W-1:0] i_start_block,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        lba_pkg::t_status              status;
        logic [lba_pkg::START_W-1:0]   start_block;
    } t_reply;

    logic                       tbl_used  [lba_pkg::NUM_BLOCKS];
    logic [lba_pkg::NAME_W-1:0] tbl_owner [lba_pkg::NUM_BLOCKS];
    int                         tbl_next  [lba_pkg::NUM_BLOCKS];
    t_reply                     owed_replies [$];
    int                         fail_count = 0;

    // Lowest used block owned by the name, or -1.
    function automatic int find_owner(input logic [lba_pkg::NAME_W-1:0] nm);
        for (int i = 0; i < lba_pkg::NUM_BLOCKS; i++)
            if (tbl_used[i] && tbl_owner[i] == nm)
                return i;
        return -1;
    endfunction

    // Update the table for one request and return the reply it earns.
    function automatic t_reply apply_request(input logic act,
                                             input logic [lba_pkg::NAME_W-1:0] nm,
                                             input logic [lba_pkg::WANT_W-1:0] cnt);
        t_reply rep;
        int     pos;
        int     run;
        int     cur;
        int     nxt;
        rep.status      = lba_pkg::ST_OK;
        rep.start_block = '0;
        if (nm[lba_pkg::NAME_W-1 -: 8] == 8'd0) begin
            rep.status = lba_pkg::ST_EMPTY;
        end else if (act == 1'b0) begin
            if (find_owner(nm) >= 0) begin
                rep.status = lba_pkg::ST_TAKEN;
            end else if (cnt == '0) begin
                rep.status = lba_pkg::ST_ZERO;
            end else begin
                pos = 0;
                while (pos < lba_pkg::NUM_BLOCKS && tbl_used[pos])
                    pos++;
                // a full table leaves run at zero
                run = 0;
                while (pos + run < lba_pkg::NUM_BLOCKS && run < cnt && !tbl_used[pos + run])
                    run++;
                if (run < cnt) begin
                    rep.status = lba_pkg::ST_NOSPACE;
                end else begin
                    for (int k = 0; k < cnt; k++) begin
                        tbl_used[pos + k]  = 1'b1;
                        tbl_owner[pos + k] = nm;
                        tbl_next[pos + k]  = (k + 1 < cnt) ? pos + k + 1 : pos + k;
                    end
                    rep.start_block = pos[lba_pkg::START_W-1:0];
                end
            end
        end else begin
            cur = find_owner(nm);
            if (cur < 0) begin
                rep.status = lba_pkg::ST_NOTFOUND;
            end else begin
                rep.start_block = cur[lba_pkg::START_W-1:0];
                // walk the chain; stop at a self link or one off the table
                for (int steps = 0; steps < lba_pkg::NUM_BLOCKS; steps++) begin
                    nxt = tbl_next[cur];
                    tbl_used[cur]  = 1'b0;
                    tbl_owner[cur] = '0;
                    tbl_next[cur]  = 0;
                    if (nxt == cur || nxt >= lba_pkg::NUM_BLOCKS)
                        break;
                    cur = nxt;
                end
            end
        end
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < lba_pkg::NUM_BLOCKS; i++) begin
                tbl_used[i]  = 1'b0;
                tbl_owner[i] = '0;
                tbl_next[i]  = 0;
            end
            owed_replies.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                owed_replies.push_back(apply_request(i_action, i_file_name, i_block_count));
            if (i_rsp_valid && i_rsp_ready) begin
                if (owed_replies.size() == 0) begin
                    $error("reply beat with none expected: status %0d start_block %0d",
                           i_status, i_start_block);
                    fail_count++;
                end else begin
                    want = owed_replies.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fail_count++;
                    end
                    if (i_start_block !== want.start_block) begin
                        $error("start_block: expected %0d, actual %0d",
                               want.start_block, i_start_block);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= owed_replies.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: verif/linked_block_allocator_tb.sv
`timescale 1ns / 1ps
// Top of the linked_block_allocator testbench: clock, reset, request and reply
// traffic, and the verdict. Depends on lba_pkg, lba_checker and the block itself.
module linked_block_allocator_tb;

    localparam int RAND_ITEMS   = 750;
    localparam int DRAIN_CYCLES = 4 * lba_pkg::NUM_BLOCKS;
    localparam int POOL_SIZE    = 12;

    logic                        i_clk;
    logic                        i_rst_n       = 1'b0;
    logic                        i_valid       = 1'b0;
    logic                        i_action      = 1'b0;
    logic [lba_pkg::NAME_W-1:0]  i_file_name   = '0;
    logic [lba_pkg::WANT_W-1:0]  i_block_count = '0;
    logic                        i_ready       = 1'b0;
    logic                        o_ready;
    logic                        o_valid;
    logic [2:0]                  o_status;
    logic [lba_pkg::START_W-1:0] o_start_block;

    int                          fail_count;
    int                          pending;
    bit                          tx_calm   = 1'b0;
    int                          rx_hold   = 0;
    int                          rx_beats  = 0;
    logic [lba_pkg::NAME_W-1:0]  name_pool [POOL_SIZE];

    linked_block_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_file_name   (i_file_name),
        .i_block_count (i_block_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_start_block (o_start_block)
    );

    lba_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_action      (i_action),
        .i_file_name   (i_file_name),
        .i_block_count (i_block_count),
        .i_rsp_valid   (o_valid),
        .i_rsp_ready   (i_ready),
        .i_status      (o_status),
        .i_start_block (o_start_block),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #15ms;
        $display("FAILURE");
        $finish;
    end

    // Reply side: after each beat hold ready low for a random stall, none in calm stretches.
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_hold <= 0;
        end else if (i_ready && o_valid) begin
            rx_beats <= rx_beats + 1;
            w = ((rx_beats % 64) >= 48) ? 0 : $urandom_range(0, 9);
            if (w > 0) begin
                i_ready <= 1'b0;
                rx_hold <= w - 1;
            end
        end else if (!i_ready) begin
            if (rx_hold == 0)
                i_ready <= 1'b1;
            else
                rx_hold <= rx_hold - 1;
        end
    end

    // Present one request after a random gap and hold it until the beat is taken.
    task automatic send_req(input logic act, input logic [lba_pkg::NAME_W-1:0] nm,
                            input logic [lba_pkg::WANT_W-1:0] cnt);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_file_name   <= nm;
        i_block_count <= cnt;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    initial begin
        int                         r;
        int                         s;
        logic                       act;
        logic [lba_pkg::NAME_W-1:0] nm;
        logic [lba_pkg::WANT_W-1:0] cnt;
        logic [7:0]                 hi;
        logic [7:0]                 lo;

        // names come in pairs that share the first character
        for (int k = 0; k < POOL_SIZE / 2; k++) begin
            hi = 8'($urandom_range(1, 255));
            lo = 8'($urandom_range(0, 255));
            name_pool[2 * k]     = {hi, lo};
            name_pool[2 * k + 1] = {hi, lo ^ 8'($urandom_range(1, 255))};
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_req(1'b0, 16'h0041, 8'd5);     // empty name on add
        send_req(1'b1, 16'h00FF, 8'd0);     // empty name on delete
        send_req(1'b1, 16'h4142, 8'd0);     // delete of a name not held
        send_req(1'b0, 16'h4142, 8'd0);     // zero size
        send_req(1'b0, 16'h4142, 8'd3);
        send_req(1'b0, 16'h4142, 8'd0);     // taken wins over zero size
        send_req(1'b0, 16'h0000, 8'd0);     // empty wins over zero size
        send_req(1'b0, 16'hFFFF, 8'd128);   // run too short
        send_req(1'b0, 16'hFFFF, 8'd1);
        send_req(1'b0, 16'h4143, 8'd4);     // differs only in the low byte
        send_req(1'b1, 16'h4142, 8'd255);
        send_req(1'b0, 16'h4344, 8'd4);     // first free run is only three long
        send_req(1'b0, 16'h4344, 8'd3);
        send_req(1'b1, 16'hFFFF, 8'd0);
        send_req(1'b1, 16'h4143, 8'd0);
        send_req(1'b1, 16'h4344, 8'd0);
        send_req(1'b0, 16'h8000, 8'd128);   // whole table
        send_req(1'b0, 16'h0101, 8'd1);     // no free block at all
        send_req(1'b0, 16'h8000, 8'd1);
        send_req(1'b1, 16'h8000, 8'd0);     // longest chain walk
        send_req(1'b1, 16'h8000, 8'd0);
        send_req(1'b0, 16'h7F00, 8'd127);
        send_req(1'b0, 16'h0180, 8'd1);     // lands on the last block
        send_req(1'b1, 16'h0180, 8'd0);
        send_req(1'b1, 16'h7F00, 8'd0);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            tx_calm = ((n / 40) % 4) == 3;
            r = $urandom_range(0, 99);
            if (r < 5) begin
                act = 1'($urandom_range(0, 1));
                nm  = {8'h00, 8'($urandom_range(0, 255))};
                cnt = 8'($urandom_range(0, 128));
            end else if (r < 10) begin
                act = 1'($urandom_range(0, 1));
                nm  = 16'($urandom_range(0, 65535));
                cnt = 8'($urandom_range(0, 128));
            end else begin
                act = ($urandom_range(0, 99) < 45);
                nm  = name_pool[$urandom_range(0, POOL_SIZE - 1)];
                s   = $urandom_range(0, 99);
                if (act)
                    cnt = 8'($urandom_range(0, 128));
                else if (s < 4)
                    cnt = '0;
                else if (s < 8)
                    cnt = 8'($urandom_range(64, 128));
                else if (s < 10)
                    cnt = 8'd128;
                else
                    cnt = 8'($urandom_range(1, 12));
            end
            send_req(act, nm, cnt);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
